>>> hdl/bph_pkg.sv
`timescale 1ns / 1ps

package bph_pkg;

  // Board encoding fixed by the port widths
  localparam int unsigned INPUT_SQUARE_BITS = 25;
  localparam int unsigned CARD_W            = 4;
  localparam int unsigned BOARD_COUNT       = 4;
  localparam int unsigned CARD_SLOTS        = 5;
  localparam int unsigned HOLDER_COUNT      = 3;

  // Key generator constants
  localparam logic [63:0] GEN_SEED   = 64'd6394358446697381921;
  localparam logic [63:0] MIX_FACTOR = 64'd2685821657736338717;
  localparam int unsigned XS_SHR_A   = 12;
  localparam int unsigned XS_SHL     = 25;
  localparam int unsigned XS_SHR_B   = 27;

  // Owner of a card key
  typedef enum logic [1:0] {
    HOLDER_WHITE = 2'd0,
    HOLDER_BLACK = 2'd1,
    HOLDER_SIDE  = 2'd2
  } holder_e;

  // One xorshift step of the generator word
  function automatic logic [63:0] xorshift(input logic [63:0] w);
    logic [63:0] t;
    t = w ^ (w >> XS_SHR_A);
    t = t ^ (t << XS_SHL);
    t = t ^ (t >> XS_SHR_B);
    return t;
  endfunction

endpackage

>>> hdl/bph_key_ram.sv
`timescale 1ns / 1ps

module bph_key_ram #(
  parameter int unsigned DEPTH = 149,
  parameter int unsigned AW    = 8
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [63:0]   wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [63:0]   rdata_o
);

  logic [63:0] mem [DEPTH];
  logic [63:0] rdata_q;

  // Write the key, register the read word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/bph_keygen.sv
`timescale 1ns / 1ps

module bph_keygen #(
  parameter int unsigned KEY_COUNT = 149,
  parameter int unsigned AW        = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  output logic          we_o,
  output logic [AW-1:0] waddr_o,
  output logic [63:0]   wdata_o,
  output logic          fill_done_o
);
  import bph_pkg::*;

  localparam logic [2:0] PhShift = 3'd0;
  localparam logic [2:0] PhLoLo  = 3'd1;
  localparam logic [2:0] PhLoHi  = 3'd2;
  localparam logic [2:0] PhHiLo  = 3'd3;
  localparam logic [2:0] PhWrite = 3'd4;

  logic [2:0]    phase_q, phase_d;
  logic [63:0]   gen_q, gen_d;
  logic [AW-1:0] cnt_q, cnt_d;
  logic          done_q, done_d;
  logic [63:0]   p0_q, p0_d;
  logic [31:0]   hi_q, hi_d;
  logic [31:0]   mul_a, mul_b;
  logic [63:0]   prod;

  // Share one 32x32 multiplier across the three partial products
  always_comb begin
    unique case (phase_q)
      PhLoHi: begin
        mul_a = gen_q[31:0];
        mul_b = MIX_FACTOR[63:32];
      end
      PhHiLo: begin
        mul_a = gen_q[63:32];
        mul_b = MIX_FACTOR[31:0];
      end
      default: begin
        mul_a = gen_q[31:0];
        mul_b = MIX_FACTOR[31:0];
      end
    endcase
    prod = {32'd0, mul_a} * {32'd0, mul_b};
  end

  // Step the generator, build the key, write it
  always_comb begin
    phase_d = phase_q;
    gen_d   = gen_q;
    cnt_d   = cnt_q;
    done_d  = done_q;
    p0_d    = p0_q;
    hi_d    = hi_q;
    we_o    = 1'b0;
    if (!done_q) begin
      unique case (phase_q)
        PhShift: begin
          gen_d   = xorshift(gen_q);
          phase_d = PhLoLo;
        end
        PhLoLo: begin
          p0_d    = prod;
          phase_d = PhLoHi;
        end
        PhLoHi: begin
          hi_d    = prod[31:0];
          phase_d = PhHiLo;
        end
        PhHiLo: begin
          hi_d    = hi_q + prod[31:0];
          phase_d = PhWrite;
        end
        PhWrite: begin
          we_o    = 1'b1;
          phase_d = PhShift;
          cnt_d   = cnt_q + AW'(1);
          if (cnt_q == AW'(KEY_COUNT - 1)) begin
            done_d = 1'b1;
          end
        end
        default: phase_d = PhShift;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhShift;
      gen_q   <= GEN_SEED;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      gen_q   <= gen_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p0_q <= p0_d;
    hi_q <= hi_d;
  end

  assign waddr_o     = cnt_q;
  assign wdata_o     = p0_q + {hi_q, 32'd0};
  assign fill_done_o = done_q;

endmodule

>>> hdl/bph_scan.sv
`timescale 1ns / 1ps

module bph_scan #(
  parameter int unsigned SQUARES     = 25,
  parameter int unsigned PIECE_KINDS = 2,
  parameter int unsigned CARD_TYPES  = 16,
  parameter int unsigned AW          = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic fill_done_i,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic [bph_pkg::BOARD_COUNT-1:0][bph_pkg::INPUT_SQUARE_BITS-1:0] squares_i,
  input  logic [bph_pkg::CARD_SLOTS-1:0][bph_pkg::CARD_W-1:0]             cards_i,
  input  logic black_to_move_i,
  output logic          re_o,
  output logic [AW-1:0] raddr_o,
  input  logic [63:0]   rdata_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [63:0]   board_hash_o
);
  import bph_pkg::*;

  localparam int unsigned UsedSq = (SQUARES < INPUT_SQUARE_BITS) ? SQUARES : INPUT_SQUARE_BITS;
  localparam logic [INPUT_SQUARE_BITS-1:0] SqMask =
    {INPUT_SQUARE_BITS{1'b1}} >> (INPUT_SQUARE_BITS - UsedSq);
  localparam int unsigned CardBase  = 2 * PIECE_KINDS * SQUARES;
  localparam int unsigned TurnIndex = CardBase + HOLDER_COUNT * CARD_TYPES;
  localparam int unsigned SqIdxW    = $clog2(INPUT_SQUARE_BITS);

  logic [BOARD_COUNT-1:0][INPUT_SQUARE_BITS-1:0] board_q, board_d;
  logic [CARD_SLOTS-1:0][CARD_W-1:0]             card_q;
  logic [CARD_SLOTS-1:0] card_pend_q, card_pend_d;
  logic                  turn_pend_q, turn_pend_d;
  logic                  busy_q, busy_d;
  logic                  rd_q;
  logic [63:0]           acc_q, acc_d;
  logic                  out_valid_q, out_valid_d;
  logic [63:0]           out_q;

  logic                         accept;
  logic                         any_board;
  logic [1:0]                   bsel;
  logic [INPUT_SQUARE_BITS-1:0] cur, lsb;
  logic [SqIdxW-1:0]            sq;
  logic [AW-1:0]                bbase;
  logic [2:0]                   csel;
  logic [CARD_W-1:0]            cval;
  holder_e                      holder;
  logic                         finish;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = fill_done_i && !busy_q;
  assign any_board  = |board_q;

  // Pick the first board with a square left and its lowest set bit
  always_comb begin
    bsel = 2'd0;
    for (int b = BOARD_COUNT - 1; b >= 0; b--) begin
      if (|board_q[b]) begin
        bsel = 2'(b);
      end
    end
    cur = board_q[bsel];
    lsb = cur & (~cur + INPUT_SQUARE_BITS'(1));
    sq  = '0;
    for (int i = 0; i < INPUT_SQUARE_BITS; i++) begin
      if (lsb[i]) begin
        sq = sq | SqIdxW'(i);
      end
    end
    case (bsel)
      2'd0: bbase = '0;
      2'd1: bbase = AW'(SQUARES);
      2'd2: bbase = AW'(PIECE_KINDS * SQUARES);
      default: bbase = AW'((PIECE_KINDS + 1) * SQUARES);
    endcase
  end

  // Pick the first pending card and its holder
  always_comb begin
    csel = 3'd0;
    for (int c = CARD_SLOTS - 1; c >= 0; c--) begin
      if (card_pend_q[c]) begin
        csel = 3'(c);
      end
    end
    cval = card_q[csel];
    case (csel) inside
      3'd0, 3'd1: holder = HOLDER_WHITE;
      3'd2, 3'd3: holder = HOLDER_BLACK;
      default:    holder = HOLDER_SIDE;
    endcase
  end

  // Issue one key read per cycle, fold the returned keys
  always_comb begin
    board_d     = board_q;
    card_pend_d = card_pend_q;
    turn_pend_d = turn_pend_q;
    busy_d      = busy_q;
    acc_d       = acc_q;
    out_valid_d = out_valid_q;
    re_o        = 1'b0;
    raddr_o     = bbase + AW'(sq);
    finish      = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (rd_q) begin
      acc_d = acc_q ^ rdata_i;
    end

    if (busy_q) begin
      if (any_board) begin
        re_o          = 1'b1;
        board_d[bsel] = cur & ~lsb;
      end else if (|card_pend_q) begin
        re_o              = 1'b1;
        raddr_o           = AW'(CardBase) + (AW'(cval) << 1) + AW'(cval) + AW'(holder);
        card_pend_d[csel] = 1'b0;
      end else if (turn_pend_q) begin
        re_o        = 1'b1;
        raddr_o     = AW'(TurnIndex);
        turn_pend_d = 1'b0;
      end else if (!rd_q && (!out_valid_q || out_ready_i)) begin
        finish      = 1'b1;
        busy_d      = 1'b0;
        out_valid_d = 1'b1;
      end
    end

    if (accept) begin
      busy_d = 1'b1;
      acc_d  = '0;
      for (int b = 0; b < BOARD_COUNT; b++) begin
        board_d[b] = ((b % 2) < PIECE_KINDS) ? (squares_i[b] & SqMask) : '0;
      end
      for (int c = 0; c < CARD_SLOTS; c++) begin
        card_pend_d[c] = {1'b0, cards_i[c]} < (CARD_W + 1)'(CARD_TYPES);
      end
      turn_pend_d = black_to_move_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      board_q     <= '0;
      card_pend_q <= '0;
      turn_pend_q <= 1'b0;
      busy_q      <= 1'b0;
      rd_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      board_q     <= board_d;
      card_pend_q <= card_pend_d;
      turn_pend_q <= turn_pend_d;
      busy_q      <= busy_d;
      rd_q        <= re_o;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold card numbers, accumulator and result beat
  always_ff @(posedge clk_i) begin
    if (accept) begin
      card_q <= cards_i;
    end
    acc_q <= acc_d;
    if (finish) begin
      out_q <= acc_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign board_hash_o = out_q;

endmodule

>>> hdl/board_position_hash.sv
`timescale 1ns / 1ps

// Channel | Direction | Handshake             | Beat
// in      | input     | in_valid_i/in_ready_o  | four square bitboards, five cards, side
// out     | output    | out_valid_o/out_ready_i| board_hash_o (64 bits)
//
// After reset the key store is filled from the generator, each key taking a shift, three partial
// products on one shared 32x32 multiplier and a write; in_ready_o stays low until done.
// A board reads one key per occupied square, per in-range card and, when black is to move,
// for the turn key, one key read per cycle, and folds them into its result beat.
// A waiting result beat does not block acceptance of the next board; the scan holds only
// when it finishes while the previous beat is still unread.
module board_position_hash #(
  parameter int unsigned SQUARES     = 25,
  parameter int unsigned PIECE_KINDS = 2,
  parameter int unsigned CARD_TYPES  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [bph_pkg::INPUT_SQUARE_BITS-1:0] white_kind0_squares_i,
  input  logic [bph_pkg::INPUT_SQUARE_BITS-1:0] white_kind1_squares_i,
  input  logic [bph_pkg::INPUT_SQUARE_BITS-1:0] black_kind0_squares_i,
  input  logic [bph_pkg::INPUT_SQUARE_BITS-1:0] black_kind1_squares_i,
  input  logic [bph_pkg::CARD_W-1:0]            white_card_first_i,
  input  logic [bph_pkg::CARD_W-1:0]            white_card_second_i,
  input  logic [bph_pkg::CARD_W-1:0]            black_card_first_i,
  input  logic [bph_pkg::CARD_W-1:0]            black_card_second_i,
  input  logic [bph_pkg::CARD_W-1:0]            spare_card_i,
  input  logic                                  black_to_move_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] board_hash_o
);
  import bph_pkg::*;

  localparam int unsigned KeyCount = 2 * PIECE_KINDS * SQUARES + HOLDER_COUNT * CARD_TYPES + 1;
  localparam int unsigned Aw       = $clog2(KeyCount);

  logic          we;
  logic [Aw-1:0] waddr;
  logic [63:0]   wdata;
  logic          fill_done;
  logic          re;
  logic [Aw-1:0] raddr;
  logic [63:0]   rdata;

  logic [BOARD_COUNT-1:0][INPUT_SQUARE_BITS-1:0] squares;
  logic [CARD_SLOTS-1:0][CARD_W-1:0]             cards;

  assign squares = {black_kind1_squares_i, black_kind0_squares_i,
                    white_kind1_squares_i, white_kind0_squares_i};
  assign cards   = {spare_card_i, black_card_second_i, black_card_first_i,
                    white_card_second_i, white_card_first_i};

  bph_keygen #(
    .KEY_COUNT(KeyCount),
    .AW       (Aw)
  ) u_keygen (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .we_o       (we),
    .waddr_o    (waddr),
    .wdata_o    (wdata),
    .fill_done_o(fill_done)
  );

  bph_key_ram #(
    .DEPTH(KeyCount),
    .AW   (Aw)
  ) u_key_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  bph_scan #(
    .SQUARES    (SQUARES),
    .PIECE_KINDS(PIECE_KINDS),
    .CARD_TYPES (CARD_TYPES),
    .AW         (Aw)
  ) u_scan (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fill_done_i    (fill_done),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .squares_i      (squares),
    .cards_i        (cards),
    .black_to_move_i(black_to_move_i),
    .re_o           (re),
    .raddr_o        (raddr),
    .rdata_i        (rdata),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .board_hash_o   (board_hash_o)
  );

  // Fill writes and scan reads never share a cycle
  a_no_rw_overlap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(we && re))
    else $error("key store written and read in the same cycle");

  // The fill completes once and stays complete
  a_fill_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_done |=> fill_done)
    else $error("fill done dropped");

  // No key is read before the store is filled
  a_read_after_fill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    re |-> fill_done)
    else $error("key read during fill");

  // No write follows the end of the fill
  a_no_write_after_fill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_done |-> !we)
    else $error("key write after fill");

endmodule
